// ===== rtl/core/bw_pkg.sv =====
`timescale 1ns / 1ps
// Package for the barycentric weights core: payload structs, register map,
// field widths and the 32-bit saturation helper. No dependencies.
package bw_pkg;

  localparam int COORD_W  = 16;
  localparam int WEIGHT_W = 32;
  localparam int CFG_AW   = 5;
  localparam int CFG_DW   = 32;

  // Register indexes, byte address = 4 * index
  localparam logic [2:0] REG_VERT1_X       = 3'd0;
  localparam logic [2:0] REG_VERT1_Y       = 3'd1;
  localparam logic [2:0] REG_VERT2_X       = 3'd2;
  localparam logic [2:0] REG_VERT2_Y       = 3'd3;
  localparam logic [2:0] REG_VERT3_X       = 3'd4;
  localparam logic [2:0] REG_VERT3_Y       = 3'd5;
  localparam logic [2:0] REG_SCALE_FIRST   = 3'd6;
  localparam logic [2:0] REG_SCALE_SECOND  = 3'd7;

  // 1.0 in Q2.30
  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

  typedef struct packed {
    logic signed [COORD_W-1:0] pixel_x;
    logic signed [COORD_W-1:0] pixel_y;
  } pixel_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight_a;
    logic signed [WEIGHT_W-1:0] weight_b;
    logic signed [WEIGHT_W-1:0] weight_c;
  } weights_t;

  // Clamp a wide signed value to the 32-bit signed range
  function automatic logic signed [31:0] sat32(input logic signed [60:0] v);
    logic signed [60:0] max_v;
    logic signed [60:0] min_v;
    max_v = 61'sd2147483647;
    min_v = -61'sd2147483648;
    if (v > max_v) begin
      return 32'sh7FFF_FFFF;
    end else if (v < min_v) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

// ===== rtl/core/barycentric_weights_core.sv =====
`timescale 1ns / 1ps
// Barycentric weights core: six-stage pipeline with APB register file.
// Depends on bw_pkg (payload structs, register map, saturation).
//
// Channel   Direction  Handshake            Word
// in_       in         in_valid/in_ready    bw_pkg::pixel_t   (pixel_x, pixel_y)
// out_      out        out_valid/out_ready  bw_pkg::weights_t (weight_a/b/c)
// cfg_      in/out     APB psel/penable     8 registers, 32-bit data
//
// One pixel enters per clock while no stalled output backs up the pipe; the stages
// are products, edge sum, scale partial products, rounding, saturation and third
// weight, and each holds its own pixel, so new pixels enter before earlier ones leave.
// Synchronous active-low reset clears the stage valid bits and the configuration registers.
// A stalled output holds its word; stalls back up stage by stage and free
// slots still fill, so nothing is lost or repeated.
module barycentric_weights_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  bw_pkg::pixel_t              in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output bw_pkg::weights_t            out_data,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [bw_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [bw_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [bw_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                        cfg_pready
);

  localparam int NSTG = 6;

  // ---------------- register file ----------------
  logic signed [15:0] v1x_r, v1y_r, v2x_r, v2y_r, v3x_r, v3y_r;
  logic signed [31:0] ka_r, kb_r;
  logic               cfg_wr;
  logic [2:0]         cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1x_r <= '0;
      v1y_r <= '0;
      v2x_r <= '0;
      v2y_r <= '0;
      v3x_r <= '0;
      v3y_r <= '0;
      ka_r  <= '0;
      kb_r  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        bw_pkg::REG_VERT1_X:      v1x_r <= cfg_pwdata[15:0];
        bw_pkg::REG_VERT1_Y:      v1y_r <= cfg_pwdata[15:0];
        bw_pkg::REG_VERT2_X:      v2x_r <= cfg_pwdata[15:0];
        bw_pkg::REG_VERT2_Y:      v2y_r <= cfg_pwdata[15:0];
        bw_pkg::REG_VERT3_X:      v3x_r <= cfg_pwdata[15:0];
        bw_pkg::REG_VERT3_Y:      v3y_r <= cfg_pwdata[15:0];
        bw_pkg::REG_SCALE_FIRST:  ka_r  <= cfg_pwdata;
        bw_pkg::REG_SCALE_SECOND: kb_r  <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      bw_pkg::REG_VERT1_X:      cfg_prdata = {16'h0000, v1x_r};
      bw_pkg::REG_VERT1_Y:      cfg_prdata = {16'h0000, v1y_r};
      bw_pkg::REG_VERT2_X:      cfg_prdata = {16'h0000, v2x_r};
      bw_pkg::REG_VERT2_Y:      cfg_prdata = {16'h0000, v2y_r};
      bw_pkg::REG_VERT3_X:      cfg_prdata = {16'h0000, v3x_r};
      bw_pkg::REG_VERT3_Y:      cfg_prdata = {16'h0000, v3y_r};
      bw_pkg::REG_SCALE_FIRST:  cfg_prdata = ka_r;
      bw_pkg::REG_SCALE_SECOND: cfg_prdata = kb_r;
      default:                  cfg_prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] v_nxt;
  logic [NSTG-1:0] rdy;

  // A stage takes a word when it is empty or its word moves on
  always_comb begin
    rdy[NSTG-1] = !v_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    v_nxt[0] = rdy[0] ? in_valid : v_r[0];
    for (int k = 1; k < NSTG; k++) begin
      v_nxt[k] = rdy[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NSTG-1];

  // ---------------- stage 1: edge products ----------------
  // Edge A runs from vertex 2 to vertex 3, edge B from vertex 3 to vertex 1
  logic signed [16:0] dya, dxa, dyb, dxb;
  logic signed [32:0] s1_tya_r, s1_txa_r, s1_tyb_r, s1_txb_r;
  logic signed [31:0] s1_ca1_r, s1_ca2_r, s1_cb1_r, s1_cb2_r;

  assign dya = $signed({v2y_r[15], v2y_r}) - $signed({v3y_r[15], v3y_r});
  assign dxa = $signed({v3x_r[15], v3x_r}) - $signed({v2x_r[15], v2x_r});
  assign dyb = $signed({v3y_r[15], v3y_r}) - $signed({v1y_r[15], v1y_r});
  assign dxb = $signed({v1x_r[15], v1x_r}) - $signed({v3x_r[15], v3x_r});

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_tya_r <= 33'(dya) * 33'(in_data.pixel_x);
      s1_txa_r <= 33'(dxa) * 33'(in_data.pixel_y);
      s1_tyb_r <= 33'(dyb) * 33'(in_data.pixel_x);
      s1_txb_r <= 33'(dxb) * 33'(in_data.pixel_y);
      s1_ca1_r <= 32'(v2x_r) * 32'(v3y_r);
      s1_ca2_r <= 32'(v3x_r) * 32'(v2y_r);
      s1_cb1_r <= 32'(v3x_r) * 32'(v1y_r);
      s1_cb2_r <= 32'(v1x_r) * 32'(v3y_r);
    end
  end

  // ---------------- stage 2: edge sums, Q.8 ----------------
  logic signed [35:0] s2_ea_r, s2_eb_r;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2_ea_r <= 36'(s1_tya_r) + 36'(s1_txa_r) + 36'(s1_ca1_r) - 36'(s1_ca2_r);
      s2_eb_r <= 36'(s1_tyb_r) + 36'(s1_txb_r) + 36'(s1_cb1_r) - 36'(s1_cb2_r);
    end
  end

  // ---------------- stage 3: scale partial products ----------------
  // Split each scale into a signed high half and an unsigned low half
  logic signed [16:0] ka_lo, kb_lo;
  logic signed [15:0] ka_hi, kb_hi;
  logic signed [52:0] s3_pla_r, s3_plb_r;
  logic signed [51:0] s3_pha_r, s3_phb_r;

  assign ka_lo = $signed({1'b0, ka_r[15:0]});
  assign kb_lo = $signed({1'b0, kb_r[15:0]});
  assign ka_hi = ka_r[31:16];
  assign kb_hi = kb_r[31:16];

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s3_pla_r <= 53'(s2_ea_r) * 53'(ka_lo);
      s3_plb_r <= 53'(s2_eb_r) * 53'(kb_lo);
      s3_pha_r <= 52'(s2_ea_r) * 52'(ka_hi);
      s3_phb_r <= 52'(s2_eb_r) * 52'(kb_hi);
    end
  end

  // ---------------- stage 4: round low part ----------------
  logic signed [52:0] rnd_a, rnd_b;
  logic signed [44:0] s4_qa_r, s4_qb_r;
  logic signed [51:0] s4_pha_r, s4_phb_r;

  assign rnd_a = s3_pla_r + 53'sd128;
  assign rnd_b = s3_plb_r + 53'sd128;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s4_qa_r  <= rnd_a[52:8];
      s4_qb_r  <= rnd_b[52:8];
      s4_pha_r <= s3_pha_r;
      s4_phb_r <= s3_phb_r;
    end
  end

  // ---------------- stage 5: combine and saturate ----------------
  logic signed [60:0] sum_a, sum_b;
  logic signed [31:0] s5_wa_r, s5_wb_r;

  assign sum_a = (61'(s4_pha_r) <<< 8) + 61'(s4_qa_r);
  assign sum_b = (61'(s4_phb_r) <<< 8) + 61'(s4_qb_r);

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s5_wa_r <= bw_pkg::sat32(sum_a);
      s5_wb_r <= bw_pkg::sat32(sum_b);
    end
  end

  // ---------------- stage 6: third weight, output word ----------------
  logic signed [33:0] wc_full;
  bw_pkg::weights_t   out_r;

  assign wc_full = bw_pkg::ONE_Q30 - 34'(s5_wa_r) - 34'(s5_wb_r);

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      out_r.weight_a <= s5_wa_r;
      out_r.weight_b <= s5_wb_r;
      out_r.weight_c <= bw_pkg::sat32(61'(wc_full));
    end
  end

  assign out_data = out_r;

  // ---------------- assertions ----------------
  logic signed [33:0] chk_sum;

  assign chk_sum = 34'(out_r.weight_a) + 34'(out_r.weight_b) + 34'(out_r.weight_c);

  // Weights add to one unless the third one clipped
  a_weights_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (chk_sum == bw_pkg::ONE_Q30) ||
                  (out_r.weight_c == 32'sh7FFF_FFFF) ||
                  (out_r.weight_c == 32'sh8000_0000))
    else $error("weights do not sum to one");

  // A full pipe with a stalled output takes no new word
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    ((&v_r) && !out_ready) |-> !in_ready)
    else $error("input taken while pipeline full and stalled");

  // A blocked third stage keeps its word
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[2] && !rdy[2]) |=> v_r[2])
    else $error("stalled stage dropped its word");

  // An empty pipe with no new input must not show a word at the output before any word could reach it
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r == '0 && !in_valid) |=> ##4 !out_valid)
    else $error("output word appeared without an input");

endmodule
